>>> design/trrd_pkg.sv
package trrd_pkg;

	localparam int NUM_LEN = 4;
	localparam int STREAM_W = 2;
	localparam int LEN_W = 13;
	localparam int DLY_W = 16;
	localparam int USE_W = 3;
	localparam int DATA_W = 32;
	localparam int LEVEL_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int NUM_OUTPUTS_DEF = 4;
	localparam int DATA_BITS_DEF = 32;
	localparam int MAX_PACKET_DEF = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTPUTS_IN_USE = 3'd0,
		REG_PACKET_LEN_0   = 3'd1,
		REG_PACKET_LEN_1   = 3'd2,
		REG_PACKET_LEN_2   = 3'd3,
		REG_PACKET_LEN_3   = 3'd4,
		REG_TRIGGER_DELAY  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		KIND_ROUTE   = 1'b0,
		KIND_DISCARD = 1'b1
	} result_kind_t;

	// everything one input item causes, queued between front and back
	typedef struct packed {
		logic                disc;
		logic [STREAM_W-1:0] disc_stream;
		logic                route;
		logic [STREAM_W-1:0] route_stream;
		logic [DATA_W-1:0]   data;
		logic                start;
		logic                pend;
	} item_rec_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

>>> design/trrd_ifs.sv
interface trrd_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [trrd_pkg::DATA_W-1:0]              sample_data;
	logic signed [trrd_pkg::LEVEL_W-1:0]      trigger_level;

	modport source (output valid, sample_data, trigger_level, input ready);
	modport sink (input valid, sample_data, trigger_level, output ready);
endinterface

interface trrd_out_if;
	logic                              valid;
	logic                              ready;
	logic                              result_kind;
	logic [trrd_pkg::STREAM_W-1:0]     out_stream;
	logic [trrd_pkg::DATA_W-1:0]       out_data;
	logic                              packet_start;
	logic                              packet_end;
	logic                              last_of_item;

	modport source (output valid, result_kind, out_stream, out_data, packet_start,
		packet_end, last_of_item, input ready);
	modport sink (input valid, result_kind, out_stream, out_data, packet_start,
		packet_end, last_of_item, output ready);
endinterface

interface trrd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [trrd_pkg::CFG_IDX_W-1:0]     index;
	logic [trrd_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/trrd_front.sv
module trrd_front #(
	parameter int NUM_OUTPUTS = trrd_pkg::NUM_OUTPUTS_DEF,
	parameter int DATA_BITS = trrd_pkg::DATA_BITS_DEF,
	parameter int MAX_PACKET = trrd_pkg::MAX_PACKET_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	trrd_cfg_if.sink             cfg,
	trrd_in_if.sink              samples,
	input  logic                 full,
	output logic                 push,
	output trrd_pkg::item_rec_t  rec
);
	import trrd_pkg::*;

	typedef struct packed {
		logic                found;
		logic [STREAM_W-1:0] idx;
	} pick_t;

	localparam int MAX_USE = (1 << USE_W) - 1;
	localparam logic [DATA_W-1:0] DATA_MASK =
		(DATA_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << DATA_BITS) - 64'd1);

	// first stream at or after 'from', cyclic over n, with a non-zero length
	function automatic pick_t next_nz(input logic [USE_W-1:0] from,
			input logic [USE_W-1:0] n, input logic [NUM_LEN-1:0] nzv);
		pick_t p;
		logic [USE_W:0] idx;
		p = '0;
		for (int k = MAX_USE - 1; k >= 0; k--) begin
			idx = {1'b0, from} + (USE_W+1)'(k);
			if (idx >= {1'b0, n})
				idx = idx - {1'b0, n};
			if ((USE_W+1)'(k) < {1'b0, n} && idx < (USE_W+1)'(NUM_LEN)
					&& nzv[idx[STREAM_W-1:0]]) begin
				p.found = 1'b1;
				p.idx = idx[STREAM_W-1:0];
			end
		end
		return p;
	endfunction

	logic [USE_W-1:0]    use_q;
	logic [LEN_W-1:0]    len_q [NUM_LEN];
	logic [DLY_W-1:0]    dly_cfg_q;

	logic [STREAM_W-1:0] cur_q;
	logic [LEN_W-1:0]    pos_q;
	logic [DLY_W-1:0]    dly_q;
	logic                wait_q;
	logic                prev_zero_q;

	logic [LEN_W-1:0]    eff_len [NUM_LEN];
	logic [NUM_LEN-1:0]  nz;
	logic [USE_W-1:0]    n;
	pick_t               first_pick, skip_pick, end_pick;

	logic                accept, positive, trig;
	logic [STREAM_W-1:0] st_cur;
	logic [LEN_W-1:0]    st_pos;
	logic [DLY_W-1:0]    st_dly;
	logic                st_wait;
	logic                disc, route, start, pend, ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= USE_W'(1);
			for (int i = 0; i < NUM_LEN; i++)
				len_q[i] <= (i == 0) ? LEN_W'(1) : '0;
			dly_cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_OUTPUTS_IN_USE: use_q <= cfg.data[USE_W-1:0];
				REG_PACKET_LEN_0:   len_q[0] <= cfg.data[LEN_W-1:0];
				REG_PACKET_LEN_1:   len_q[1] <= cfg.data[LEN_W-1:0];
				REG_PACKET_LEN_2:   len_q[2] <= cfg.data[LEN_W-1:0];
				REG_PACKET_LEN_3:   len_q[3] <= cfg.data[LEN_W-1:0];
				REG_TRIGGER_DELAY:  dly_cfg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LEN; i++) begin
			eff_len[i] = (32'(len_q[i]) > MAX_PACKET) ? LEN_W'(MAX_PACKET) : len_q[i];
			nz[i] = (i < NUM_OUTPUTS) && (eff_len[i] != '0);
		end
		if (use_q == '0)
			n = USE_W'(1);
		else if (32'(use_q) > NUM_OUTPUTS)
			n = USE_W'(NUM_OUTPUTS);
		else
			n = use_q;
	end

	assign first_pick = next_nz('0, n, nz);

	assign accept = samples.valid && samples.ready;
	assign samples.ready = !full;
	assign positive = samples.trigger_level > 0;
	assign trig = prev_zero_q && positive;

	always_comb begin
		st_cur = cur_q;
		st_pos = pos_q;
		st_dly = dly_q;
		st_wait = wait_q;
		disc = 1'b0;
		route = 1'b0;
		start = 1'b0;
		pend = 1'b0;
		ok = 1'b0;
		skip_pick = '0;
		if (trig) begin
			disc = pos_q != '0;
			st_pos = '0;
			st_cur = first_pick.found ? first_pick.idx : '0;
			st_dly = dly_cfg_q;
			st_wait = dly_cfg_q != '0;
		end
		if (st_wait) begin
			if (st_dly != '0)
				st_dly = st_dly - DLY_W'(1);
			if (st_dly == '0)
				st_wait = 1'b0;
		end else begin
			ok = 1'b1;
			// current stream dropped out of use: move on without a discard
			if (!({1'b0, st_cur} < n && nz[st_cur])) begin
				skip_pick = next_nz(({1'b0, st_cur} >= n) ? '0 : {1'b0, st_cur} + USE_W'(1),
					n, nz);
				st_pos = '0;
				if (!skip_pick.found) begin
					ok = 1'b0;
					st_cur = '0;
				end else begin
					st_cur = skip_pick.idx;
				end
			end
			if (ok) begin
				route = 1'b1;
				start = st_pos == '0;
				st_pos = st_pos + LEN_W'(1);
				pend = st_pos >= eff_len[st_cur];
			end
		end
	end

	// stream that follows a completed packet
	assign end_pick = next_nz({1'b0, st_cur} + USE_W'(1), n, nz);

	always_comb begin
		rec.disc = disc;
		rec.disc_stream = cur_q;
		rec.route = route;
		rec.route_stream = st_cur;
		rec.data = samples.sample_data & DATA_MASK;
		rec.start = start;
		rec.pend = pend;
	end

	assign push = accept && (disc || route);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			pos_q <= '0;
			dly_q <= '0;
			wait_q <= 1'b0;
			prev_zero_q <= 1'b1;
		end else if (accept) begin
			prev_zero_q <= samples.trigger_level == '0;
			dly_q <= st_dly;
			wait_q <= st_wait;
			if (pend) begin
				pos_q <= '0;
				cur_q <= end_pick.found ? end_pick.idx : '0;
			end else begin
				pos_q <= st_pos;
				cur_q <= st_cur;
			end
		end
	end

endmodule

>>> design/trrd_fifo.sv
module trrd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  trrd_pkg::item_rec_t   wr_rec,
	input  logic                  pop,
	output trrd_pkg::item_rec_t   head,
	output trrd_pkg::fifo_stat_t  stat
);
	import trrd_pkg::*;

	item_rec_t        mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign do_push = push && (count_q != CNT_W'(FIFO_DEPTH));
	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign head = mem[rd_ptr_q];
	assign stat.full = count_q == CNT_W'(FIFO_DEPTH);
	assign stat.empty = count_q == '0;
	assign stat.count = count_q;

endmodule

>>> design/trrd_back.sv
module trrd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trrd_pkg::item_rec_t   head,
	input  trrd_pkg::fifo_stat_t  stat,
	output logic                  pop,
	trrd_out_if.source            results
);
	import trrd_pkg::*;

	// set once the discard of a two-result item has gone out
	logic phase_q;
	logic show_disc, last, xfer;

	assign show_disc = head.disc && !phase_q;
	assign last = !(show_disc && head.route);
	assign xfer = results.valid && results.ready;
	assign pop = xfer && last;

	always_comb begin
		results.valid = !stat.empty;
		results.result_kind = show_disc ? KIND_DISCARD : KIND_ROUTE;
		results.out_stream = show_disc ? head.disc_stream : head.route_stream;
		results.out_data = show_disc ? '0 : head.data;
		results.packet_start = !show_disc && head.start;
		results.packet_end = !show_disc && head.pend;
		results.last_of_item = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= 1'b0;
		else if (xfer)
			phase_q <= !last;
	end

endmodule

>>> design/triggered_round_robin_demux.sv
// channel   role    transfer when            payload
// cfg       sink    cfg.valid & ready        index, data (ready always high)
// samples   sink    samples.valid & ready    sample_data, trigger_level
// results   source  results.valid & ready    kind, stream, data, start, end, last
//
// One sample is taken per clock; the front updates routing state in that cycle.
// Each sample yields zero, one or two results; the back sends one per clock while
// results.ready is high; a sample with both a discard and a routed result sends the
// discard first. A four-entry queue sits between front and back; samples stall only
// when it is full. Reset is asynchronous and needs no clearing pass.
module triggered_round_robin_demux #(
	parameter int NUM_OUTPUTS = trrd_pkg::NUM_OUTPUTS_DEF,
	parameter int DATA_BITS = trrd_pkg::DATA_BITS_DEF,
	parameter int MAX_PACKET = trrd_pkg::MAX_PACKET_DEF
) (
	input logic          clk,
	input logic          arst_n,
	trrd_cfg_if.sink     cfg,
	trrd_in_if.sink      samples,
	trrd_out_if.source   results
);
	import trrd_pkg::*;

	logic       push, pop;
	item_rec_t  wr_rec, head;
	fifo_stat_t stat;

	trrd_front #(
		.NUM_OUTPUTS(NUM_OUTPUTS),
		.DATA_BITS(DATA_BITS),
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.samples(samples),
		.full(stat.full),
		.push(push),
		.rec(wr_rec)
	);

	trrd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_rec(wr_rec),
		.pop(pop),
		.head(head),
		.stat(stat)
	);

	trrd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.stat(stat),
		.pop(pop),
		.results(results)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_disc_then_route: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && results.result_kind == KIND_DISCARD
			&& !results.last_of_item
		|=> results.valid && results.result_kind == KIND_ROUTE)
		else $error("discard not followed by its routed sample");

	a_route_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.result_kind == KIND_ROUTE |-> results.last_of_item)
		else $error("routed sample not last of its item");

endmodule
